### hdl/modulo_reservation_table_binder_assert.svh
// Assertion macros shared by the binder RTL.
// Both expect i_clk and i_rst_n to be visible in the enclosing module.
`ifndef MODULO_RESERVATION_TABLE_BINDER_ASSERT_SVH
`define MODULO_RESERVATION_TABLE_BINDER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MRTB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MRTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mrtb_pkg.sv
`default_nettype none
package mrtb_pkg;

    // Table geometry
    localparam int NUM_TYPES = 4;
    localparam int MAX_UNITS = 8;
    localparam int MAX_II    = 16;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int UNIT_W  = 3;
    localparam int II_W    = 5;
    localparam int UNITS_W = 4;
    localparam int CNT_W   = 5;
    localparam int RES_W   = $clog2(MAX_II);

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Remainder unit: slot bits consumed per cycle
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = (SLOT_W + MOD_BITS - 1) / MOD_BITS;
    localparam int MOD_PAD_W = MOD_STEPS * MOD_BITS;
    localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_II     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = CFG_IDX_W'(1 + NUM_TYPES);

    // Commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [KIND_W-1:0] op_kind;
        logic [SLOT_W-1:0] time_slot;
    } t_in;

    typedef struct packed {
        logic [UNIT_W-1:0] unit_index;
        logic              rejected;
    } t_out;

    // One unit's entry; a row holds every unit of one type
    typedef struct packed {
        logic [MAX_II-1:0] busy;
        logic [CNT_W-1:0]  cnt;
    } t_unit_ent;

    typedef t_unit_ent [MAX_UNITS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SEL
    } t_state;

    function automatic logic [II_W-1:0] eff_ii(input logic [II_W-1:0] ii);
        logic [II_W-1:0] r;
        r = ii;
        if (ii == '0) begin
            r = II_W'(1);
        end else if (ii > II_W'(MAX_II)) begin
            r = II_W'(MAX_II);
        end
        return r;
    endfunction

    function automatic logic [UNITS_W-1:0] eff_units(input logic [UNITS_W-1:0] n);
        logic [UNITS_W-1:0] r;
        r = n;
        if (n > UNITS_W'(MAX_UNITS)) begin
            r = UNITS_W'(MAX_UNITS);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/mrtb_ram.sv
`default_nettype none
module mrtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read that holds while idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/mrtb_mod.sv
`default_nettype none
module mrtb_mod
    import mrtb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SLOT_W-1:0] i_dividend,
    input  wire logic [II_W-1:0]   i_divisor,
    output logic                   o_done,
    output logic      [RES_W-1:0]  o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [MOD_PAD_W-1:0] r_q;
    logic [RES_W:0]       r_rem;
    logic [II_W-1:0]      r_div;
    logic [RES_W:0]       n_rem;

    // Restoring remainder over MOD_BITS dividend bits, MSB first
    always_comb begin
        n_rem = r_rem;
        for (int b = MOD_BITS - 1; b >= 0; b--) begin
            n_rem = {n_rem[RES_W-1:0], r_q[MOD_PAD_W-MOD_BITS+b]};
            if (n_rem >= (RES_W+1)'(r_div)) begin
                n_rem = n_rem - (RES_W+1)'(r_div);
            end
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= MOD_PAD_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= r_q << MOD_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[RES_W-1:0];

endmodule
`default_nettype wire

### hdl/modulo_reservation_table_binder.sv
`default_nettype none
// Modulo reservation table binder. Each insert item takes the residue of its
// time slot modulo the initiation interval and binds the least-used unit of
// its type that holds no slot of that residue (lowest index on a tie), or
// returns rejected when every unit conflicts; a clear item empties the table.
// The table lives in one RAM row per operation type, read, updated and
// written back per insert. The block takes one item at a time: an insert waits
// for the remainder unit, which consumes 4 slot bits a cycle, before the select
// and write-back; a clear waits only for the output. A result that waits at the
// output holds the following item in its last cycle, and the input with it,
// until the result is taken. The table needs no clearing pass: each row has a
// valid bit that reset and clear drop. Configuration registers: 0 initiation
// interval, 1 to 4 unit counts of types 0 to 3, to be written only while the
// block is idle; the block itself does not enforce this.
`include "modulo_reservation_table_binder_assert.svh"
module modulo_reservation_table_binder
    import mrtb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input items
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_in                  i_data,
    // result items
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_out                      o_data,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_state r_state, n_state;

    logic [II_W-1:0]    r_ii;
    logic [UNITS_W-1:0] r_units [NUM_TYPES];
    logic [CFG_IDX_W-1:0] cfg_sel;

    logic [NUM_TYPES-1:0] r_row_vld;
    logic                 r_rd_vld;
    logic                 r_cmd;
    logic [KIND_W-1:0]    r_kind;
    logic                 r_kind_ok;

    logic       r_out_vld;
    t_out       r_out;

    logic       accept;
    logic       out_free;
    logic       s_in_ready;
    logic       s_finish;
    logic       mod_done;
    logic [RES_W-1:0] res;

    logic [ROW_W-1:0] ram_rdata;
    t_row       rd_row;
    t_row       wr_row;
    logic       ram_we;

    logic [UNITS_W-1:0] units_eff;
    logic               s_found;
    logic [UNIT_W-1:0]  s_best;
    logic [CNT_W-1:0]   s_best_cnt;

    assign accept   = i_valid && s_in_ready;
    assign out_free = !r_out_vld || i_ready;

    // Configuration registers
    assign cfg_sel = i_cfg_idx - CFG_UNITS0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ii <= II_W'(1);
            for (int t = 0; t < NUM_TYPES; t++) begin
                r_units[t] <= UNITS_W'(1);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_II) begin
                r_ii <= i_cfg_data;
            end else if (i_cfg_idx >= CFG_UNITS0 && i_cfg_idx < CFG_END) begin
                r_units[cfg_sel[KIND_W-1:0]] <= i_cfg_data[UNITS_W-1:0];
            end
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_data.command == CMD_CLEAR) ? ST_SEL : ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    n_state = out_free ? ST_IDLE : ST_SEL;
                end
            end
            ST_SEL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_in_ready = 1'b0;
        s_finish   = 1'b0;
        case (r_state)
            ST_IDLE: s_in_ready = 1'b1;
            ST_MOD:  s_finish   = mod_done && out_free;
            ST_SEL:  s_finish   = out_free;
            default: s_in_ready = 1'b0;
        endcase
    end

    // Item capture and row valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (accept && i_data.command == CMD_CLEAR) begin
            r_row_vld <= '0;
        end else if (ram_we) begin
            r_row_vld[r_kind] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_data.command;
            r_kind    <= i_data.op_kind;
            r_kind_ok <= int'(i_data.op_kind) < NUM_TYPES;
            r_rd_vld  <= r_row_vld[i_data.op_kind];
        end
    end

    // Residue of the slot, started by inserts only
    mrtb_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && i_data.command == CMD_INSERT),
        .i_dividend (i_data.time_slot),
        .i_divisor  (eff_ii(r_ii)),
        .o_done     (mod_done),
        .o_rem      (res)
    );

    // Table rows, one per operation type
    mrtb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_TYPES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_kind),
        .i_wdata (wr_row),
        .i_re    (accept),
        .i_raddr (i_data.op_kind),
        .o_rdata (ram_rdata)
    );

    assign rd_row    = r_rd_vld ? t_row'(ram_rdata) : '0;
    assign units_eff = eff_units(r_units[r_kind]);

    // Least-used free unit, lowest index on a tie
    always_comb begin
        s_found    = 1'b0;
        s_best     = '0;
        s_best_cnt = '0;
        for (int u = 0; u < MAX_UNITS; u++) begin
            if (u < int'(units_eff) && !rd_row[u].busy[res]
                    && (!s_found || rd_row[u].cnt < s_best_cnt)) begin
                s_found    = 1'b1;
                s_best     = UNIT_W'(u);
                s_best_cnt = rd_row[u].cnt;
            end
        end
    end

    // Updated row: mark the residue, bump the saturating use count
    always_comb begin
        wr_row = rd_row;
        wr_row[s_best].busy[res] = 1'b1;
        if (rd_row[s_best].cnt != COUNT_MAX) begin
            wr_row[s_best].cnt = rd_row[s_best].cnt + 1'b1;
        end
    end

    assign ram_we = s_finish && r_cmd == CMD_INSERT && r_kind_ok && s_found;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_finish) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_finish) begin
            if (r_cmd == CMD_CLEAR) begin
                r_out.unit_index <= '0;
                r_out.rejected   <= 1'b0;
            end else if (!r_kind_ok || !s_found) begin
                r_out.unit_index <= '0;
                r_out.rejected   <= 1'b1;
            end else begin
                r_out.unit_index <= s_best;
                r_out.rejected   <= 1'b0;
            end
        end
    end

    assign o_ready = s_in_ready;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Checks
    `MRTB_ASSERT_SAME(a_done_in_mod, mod_done, r_state == ST_MOD, "residue done outside MOD")
    `MRTB_ASSERT_SAME(a_bind_in_range, ram_we, UNITS_W'(s_best) < units_eff, "unit beyond count")
    `MRTB_ASSERT_SAME(a_reject_zero, r_out_vld && r_out.rejected, r_out.unit_index == '0, "reject idx")
    `MRTB_ASSERT_NEXT(a_one_at_a_time, accept, !o_ready, "item accepted while busy")

endmodule
`default_nettype wire
